// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion shorthands for the bracket checker
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled while in reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/bbc_pkg.sv =====
// ----------------------------------------------------------------------------
// bbc_pkg
// types, character codes and decode for the bracket balance checker
// ----------------------------------------------------------------------------
package bbc_pkg;

  localparam int unsigned DefStackDepth = 64;
  localparam int unsigned NumTypes      = 5;
  localparam int unsigned CharW         = 8;
  localparam int unsigned CountW        = 16;
  localparam int unsigned MaxDepthW     = 7;

  localparam logic [CharW-1:0]     DefEndMarker = 8'd46;
  localparam logic [CountW-1:0]    CountMax     = 16'hFFFF;
  localparam logic [MaxDepthW-1:0] MaxDepthSat  = 7'd127;

  // character codes
  localparam logic [CharW-1:0] ChSqOpen  = 8'h5B;
  localparam logic [CharW-1:0] ChRdOpen  = 8'h28;
  localparam logic [CharW-1:0] ChBar     = 8'h7C;
  localparam logic [CharW-1:0] ChCuOpen  = 8'h7B;
  localparam logic [CharW-1:0] ChAnOpen  = 8'h3C;
  localparam logic [CharW-1:0] ChSqClose = 8'h5D;
  localparam logic [CharW-1:0] ChRdClose = 8'h29;
  localparam logic [CharW-1:0] ChCuClose = 8'h7D;
  localparam logic [CharW-1:0] ChAnClose = 8'h3E;

  // stack entry type codes
  typedef enum logic [2:0] {
    TYPE_SQUARE = 3'd0,
    TYPE_ROUND  = 3'd1,
    TYPE_BAR    = 3'd2,
    TYPE_CURLY  = 3'd3,
    TYPE_ANGLE  = 3'd4
  } bbc_type_e;

  // decoded character
  typedef struct packed {
    logic      is_open;
    logic      is_close;
    logic      is_bar;
    bbc_type_e code;
  } bbc_dec_t;

  // stack shift control, shared by every cell
  typedef struct packed {
    logic      push;
    logic      pop;
    bbc_type_e code;
  } bbc_stk_ctrl_t;

  function automatic bbc_dec_t bbc_decode(input logic [CharW-1:0] ch);
    bbc_dec_t d;
    d = '{is_open: 1'b0, is_close: 1'b0, is_bar: 1'b0, code: TYPE_SQUARE};
    case (ch)
      ChSqOpen:  begin d.is_open = 1'b1;  d.code = TYPE_SQUARE; end
      ChRdOpen:  begin d.is_open = 1'b1;  d.code = TYPE_ROUND;  end
      ChCuOpen:  begin d.is_open = 1'b1;  d.code = TYPE_CURLY;  end
      ChAnOpen:  begin d.is_open = 1'b1;  d.code = TYPE_ANGLE;  end
      ChSqClose: begin d.is_close = 1'b1; d.code = TYPE_SQUARE; end
      ChRdClose: begin d.is_close = 1'b1; d.code = TYPE_ROUND;  end
      ChCuClose: begin d.is_close = 1'b1; d.code = TYPE_CURLY;  end
      ChAnClose: begin d.is_close = 1'b1; d.code = TYPE_ANGLE;  end
      ChBar:     begin d.is_bar = 1'b1;   d.code = TYPE_BAR;    end
      default:   begin d.code = TYPE_SQUARE; end
    endcase
    return d;
  endfunction

endpackage

// ===== rtl/bbc_cell.sv =====
// ----------------------------------------------------------------------------
// bbc_cell
// one stack entry: takes the entry above on push, the one below on pop
// ----------------------------------------------------------------------------
module bbc_cell (
  input  logic                  clk_i,
  input  bbc_pkg::bbc_stk_ctrl_t ctrl_i,
  input  bbc_pkg::bbc_type_e    above_i,
  input  bbc_pkg::bbc_type_e    below_i,
  output bbc_pkg::bbc_type_e    entry_o
);
  import bbc_pkg::*;

  bbc_type_e entry_q, entry_d;

  // shift select
  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.push) begin
      entry_d = above_i;
    end else if (ctrl_i.pop) begin
      entry_d = below_i;
    end
  end

  // entry storage, no reset needed
  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

// ===== rtl/bbc_stack.sv =====
// ----------------------------------------------------------------------------
// bbc_stack
// shift stack built from a row of cells, top of stack in cell zero
// ----------------------------------------------------------------------------
module bbc_stack #(
  parameter int unsigned STACK_DEPTH = bbc_pkg::DefStackDepth
) (
  input  logic                   clk_i,
  input  bbc_pkg::bbc_stk_ctrl_t ctrl_i,
  output bbc_pkg::bbc_type_e     top_o
);
  import bbc_pkg::*;

  bbc_type_e entry[STACK_DEPTH];

  // chain of cells fed by neighbors; top takes code, last its own
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    bbc_type_e above, below;
    if (i == 0) begin : g_first
      assign above = ctrl_i.code;
    end else begin : g_mid_above
      assign above = entry[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_last
      assign below = entry[i];
    end else begin : g_mid_below
      assign below = entry[i+1];
    end
    bbc_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl_i),
      .above_i (above),
      .below_i (below),
      .entry_o (entry[i])
    );
  end

  assign top_o = entry[0];

endmodule

// ===== rtl/bracket_balance_checker.sv =====
// A result is registered on the end-marker transaction and appears in the cycle after it is accepted.
// Throughput: one character per cycle while in_ready_o is high; a push or pop shifts the whole cell chain at once.
// A result waiting in the output register holds the input off until it is taken.
// Reset (async, active low) empties the stack, clears counts and peak, sets the
// ok flag and loads end marker 46; stack cells themselves are never cleared.
// ----------------------------------------------------------------------------
// bracket_balance_checker
// checks bracket nesting with a shift-register stack, counts openers and
// tracks peak depth, reporting one result per end marker
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bracket_balance_checker #(
  parameter int unsigned STACK_DEPTH = bbc_pkg::DefStackDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  ch_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        balanced_o,
  output logic [15:0] square_opens_o,
  output logic [15:0] round_opens_o,
  output logic [15:0] bar_opens_o,
  output logic [15:0] curly_opens_o,
  output logic [15:0] angle_opens_o,
  output logic [6:0]  max_depth_o
);
  import bbc_pkg::*;

  localparam int unsigned DepthW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned PeakW  = (DepthW > MaxDepthW) ? DepthW : MaxDepthW;
  localparam logic [DepthW-1:0] DepthFull = DepthW'(STACK_DEPTH);

  logic [CharW-1:0]  end_marker_q;
  logic [DepthW-1:0] depth_q, depth_d;
  logic [DepthW-1:0] peak_q, peak_d;
  logic              ok_q, ok_d;
  logic [CountW-1:0] count_q[NumTypes];
  logic [CountW-1:0] count_d[NumTypes];

  logic              out_valid_q, out_valid_d;
  logic              bal_q;
  logic [CountW-1:0] res_count_q[NumTypes];
  logic [MaxDepthW-1:0] res_max_q;

  bbc_dec_t      dec;
  bbc_stk_ctrl_t stk_ctrl;
  bbc_type_e     top;
  logic          in_fire, is_end;
  logic          has_top, full, bar_pops, open_req, close_match, empty_close;
  logic          do_push, do_pop;
  logic [PeakW-1:0] peak_ext;

  // handshake
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign is_end     = (ch_i == end_marker_q);

  // decode and stack operation
  always_comb begin
    dec         = bbc_decode(ch_i);
    has_top     = (depth_q != '0);
    full        = (depth_q == DepthFull);
    bar_pops    = dec.is_bar && has_top && (top == TYPE_BAR);
    open_req    = dec.is_open || (dec.is_bar && !bar_pops);
    close_match = dec.is_close && has_top && (top == dec.code);
    empty_close = dec.is_close && !has_top;
    do_push     = in_fire && open_req && !full;
    do_pop      = in_fire && (bar_pops || close_match);
    stk_ctrl    = '{push: do_push, pop: do_pop, code: dec.code};
  end

  bbc_stack #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk_i  (clk_i),
    .ctrl_i (stk_ctrl),
    .top_o  (top)
  );

  // stream state after this character
  always_comb begin
    ok_d    = ok_q && !empty_close && !(open_req && full);
    depth_d = depth_q;
    if (do_push) begin
      depth_d = depth_q + DepthW'(1);
    end else if (do_pop) begin
      depth_d = depth_q - DepthW'(1);
    end
    peak_d = (depth_d > peak_q) ? depth_d : peak_q;
    for (int k = 0; k < NumTypes; k++) begin
      count_d[k] = count_q[k];
      if (open_req && (dec.code == bbc_type_e'(3'(k))) && (count_q[k] != CountMax)) begin
        count_d[k] = count_q[k] + CountW'(1);
      end
    end
    peak_ext = PeakW'(peak_d);
  end

  // output valid
  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    if (in_fire && is_end) begin
      out_valid_d = 1'b1;
    end
  end

  // config and stream state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      end_marker_q <= DefEndMarker;
      depth_q      <= '0;
      peak_q       <= '0;
      ok_q         <= 1'b1;
      out_valid_q  <= 1'b0;
      for (int k = 0; k < NumTypes; k++) begin
        count_q[k] <= '0;
      end
    end else begin
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        end_marker_q <= cfg_data_i;
      end
      if (in_fire) begin
        if (is_end) begin
          depth_q <= '0;
          peak_q  <= '0;
          ok_q    <= 1'b1;
          for (int k = 0; k < NumTypes; k++) begin
            count_q[k] <= '0;
          end
        end else begin
          depth_q <= depth_d;
          peak_q  <= peak_d;
          ok_q    <= ok_d;
          for (int k = 0; k < NumTypes; k++) begin
            count_q[k] <= count_d[k];
          end
        end
      end
    end
  end

  // result register, loaded on the end-marker transaction
  always_ff @(posedge clk_i) begin
    if (in_fire && is_end) begin
      bal_q     <= ok_d && (depth_d == '0);
      res_max_q <= (peak_ext > PeakW'(MaxDepthSat)) ? MaxDepthSat : peak_ext[MaxDepthW-1:0];
      for (int k = 0; k < NumTypes; k++) begin
        res_count_q[k] <= count_d[k];
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign balanced_o     = bal_q;
  assign square_opens_o = res_count_q[TYPE_SQUARE];
  assign round_opens_o  = res_count_q[TYPE_ROUND];
  assign bar_opens_o    = res_count_q[TYPE_BAR];
  assign curly_opens_o  = res_count_q[TYPE_CURLY];
  assign angle_opens_o  = res_count_q[TYPE_ANGLE];
  assign max_depth_o    = res_max_q;

  // assertions
  `ASSERT_IMPL(a_depth_bound, clk_i, rst_ni, 1'b1, depth_q <= DepthFull)
  `ASSERT_IMPL(a_peak_covers_depth, clk_i, rst_ni, 1'b1, peak_q >= depth_q)
  `ASSERT_NEXT(a_clear_after_end, clk_i, rst_ni, in_fire && is_end,
               depth_q == '0 && peak_q == '0 && ok_q && out_valid_q)
  `ASSERT_NEXT(a_result_held, clk_i, rst_ni, out_valid_q && !out_ready_i,
               out_valid_q && $stable(bal_q) && $stable(res_max_q))

endmodule
